// ===== rtl/vb128_pkg.sv =====
// Package for the base-128 varint codec: widths, codes, FSM state type and
// the step-unit result struct. No dependencies.
`default_nettype none

package vb128_pkg;

  localparam int ValueBits  = 64;
  localparam int ByteBits   = 8;
  localparam int CountBits  = 4;
  localparam int GroupBits  = 7;
  localparam int MaxGroups  = 8;
  localparam int ShiftBits  = 6;

  localparam logic [ByteBits-1:0]  GroupMask = 8'h7F;
  localparam logic [ByteBits-1:0]  ContFlag  = 8'h80;
  localparam logic [CountBits-1:0] LastGroup = 4'(MaxGroups);

  // direction register codes
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } state_t;

  // what the shared step unit hands back for the current group
  typedef struct packed {
    logic                 last;
    logic [ByteBits-1:0]  res_byte;
    logic [ValueBits-1:0] res_value;
    logic [CountBits-1:0] res_count;
    logic [ValueBits-1:0] word_next;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/vb128_if.sv =====
// Channel interfaces of the varint codec: input item, result item and the
// direction write channel. Depends on vb128_pkg.
`default_nettype none

interface vb128_item_if import vb128_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] plain_value;
  logic [ByteBits-1:0]  coded_byte;

  modport source (output valid, output plain_value, output coded_byte, input ready);
  modport sink   (input valid, input plain_value, input coded_byte, output ready);
endinterface

interface vb128_result_if import vb128_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteBits-1:0]  out_byte;
  logic                 run_last;
  logic [ValueBits-1:0] decoded_value;
  logic [CountBits-1:0] byte_count;

  modport source (output valid, output out_byte, output run_last,
                  output decoded_value, output byte_count, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input decoded_value, input byte_count, output ready);
endinterface

interface vb128_cfg_if ();
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

// ===== rtl/vb128_step.sv =====
// Shared group step unit: one group per use (7 bits, 8 for a ninth byte),
// split off (encode) or merged in (decode). Depends on vb128_pkg.
`default_nettype none

module vb128_step import vb128_pkg::*; (
  input  logic                 mode,
  input  logic [ValueBits-1:0] word,
  input  logic [CountBits-1:0] idx,
  input  logic [ByteBits-1:0]  coded_byte,
  output step_t                step
);

  logic                 ninth;
  logic [ValueBits-1:0] rest;
  logic                 cont;
  logic [ByteBits-1:0]  group;
  logic [ShiftBits-1:0] shamt;
  logic [ValueBits-1:0] merged;
  logic [CountBits-1:0] count;

  assign ninth = (idx == LastGroup);
  assign count = CountBits'(idx + 4'd1);

  // encode side: word holds the bits not yet sent
  assign rest = word >> GroupBits;
  assign cont = (rest != '0) && !ninth;

  // decode side: ninth byte is a full 8-bit group at the top
  assign group  = ninth ? coded_byte : (coded_byte & GroupMask);
  assign shamt  = ShiftBits'(idx) * ShiftBits'(GroupBits);
  assign merged = word | ({{(ValueBits-ByteBits){1'b0}}, group} << shamt);

  always_comb begin
    step = '0;
    case (mode)
      DirEncode: begin
        step.last      = !cont;
        step.res_byte  = ninth ? word[ByteBits-1:0]
                               : ((word[ByteBits-1:0] & GroupMask) | (cont ? ContFlag : '0));
        step.res_value = '0;
        step.res_count = cont ? '0 : count;
        step.word_next = rest;
      end
      DirDecode: begin
        step.last      = ninth || !coded_byte[ByteBits-1];
        step.res_byte  = '0;
        step.res_value = merged;
        step.res_count = count;
        step.word_next = merged;
      end
      default: begin
        step = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/varint_base128_codec_top.sv =====
// Top level of the unsigned 64-bit base-128 varint codec (encode/decode).
// Depends on vb128_pkg, vb128_if.sv interfaces and vb128_step.
//
//   channel | modport | transaction carries
//   --------+---------+-----------------------------------------------------
//   item    | sink    | plain_value (encode) or coded_byte (decode)
//   result  | source  | out_byte, run_last, decoded_value, byte_count
//   cfg     | sink    | direction (0 encode, 1 decode), always ready
//
// Encode: the value is taken into the word register, then one byte leaves
//   per cycle through the shared step unit for a value of n bytes (1..9);
//   item ready stays low until the last byte is in the result reg.
// Decode: one coded byte per cycle; the step unit merges the group directly.
// A stalled result holds the result register and with it the sequencer.
// rst (sync, active high) clears direction, word, group index and valid.
`default_nettype none

module varint_base128_codec_top import vb128_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  vb128_item_if.sink            item,
  vb128_result_if.source        result,
  vb128_cfg_if.sink             cfg
);

  state_t               state;
  state_t               state_next;
  logic                 direction;
  logic [ValueBits-1:0] word;      // rest to send, or partial decoded value
  logic [CountBits-1:0] idx;       // group index within the run
  step_t                step;
  logic                 unit_mode;

  logic                 res_valid;
  logic [ByteBits-1:0]  res_byte;
  logic                 res_last;
  logic [ValueBits-1:0] res_value;
  logic [CountBits-1:0] res_count;

  logic out_free;
  logic in_fire;
  logic cfg_fire;
  logic adv;       // the step unit's result is taken this cycle
  logic load_res;  // result register loads this cycle

  assign out_free = !res_valid || result.ready;
  assign in_fire  = item.valid && item.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  // The one step unit is shared: encode groups in ST_ENC, decode in idle.
  assign unit_mode = (state == ST_ENC) ? DirEncode : direction;

  vb128_step u_step (
    .mode       (unit_mode),
    .word       (word),
    .idx        (idx),
    .coded_byte (item.coded_byte),
    .step       (step)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && direction == DirEncode) state_next = ST_ENC;
      end
      ST_ENC: begin
        if (out_free && step.last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    item.ready = 1'b0;
    adv        = 1'b0;
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        item.ready = out_free;
        adv        = in_fire && direction == DirDecode;
        load_res   = adv && step.last;
      end
      ST_ENC: begin
        adv      = out_free;
        load_res = out_free;
      end
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      direction <= DirEncode;
      word      <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_fire) begin
        // any write drops a partial decode run
        direction <= cfg.direction;
        word      <= '0;
        idx       <= '0;
      end else if (in_fire && direction == DirEncode) begin
        word <= item.plain_value;
        idx  <= '0;
      end else if (adv) begin
        // end of run leaves word/idx at zero, which is the idle decode state
        word <= step.last ? '0 : step.word_next;
        idx  <= step.last ? '0 : CountBits'(idx + 4'd1);
      end

      if (load_res)            res_valid <= 1'b1;
      else if (result.ready)   res_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_byte  <= step.res_byte;
      res_last  <= step.last;
      res_value <= step.res_value;
      res_count <= step.res_count;
    end
  end

  assign result.valid         = res_valid;
  assign result.out_byte      = res_byte;
  assign result.run_last      = res_last;
  assign result.decoded_value = res_value;
  assign result.byte_count    = res_count;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for varint_base128_codec_top: queued stimulus, a clocked
// driver and monitor, and an in-bench copy of the codec behavior.
// Depends on vb128_pkg, the vb128 channel interfaces and the codec RTL.
`timescale 1ns / 1ps

module testbench;
  import vb128_pkg::*;

  localparam int SettleCycles  = 24;    // covers the encode of a nine-byte value
  localparam int HoldCycles    = 300;   // long receiver hold-off that backs up the codec
  localparam int WatchdogLimit = 5000;  // cycles without any transaction before giving up
  localparam int PhaseItems    = 32;

  typedef struct {
    logic [ValueBits-1:0] plain_value;
    logic [ByteBits-1:0]  coded_byte;
  } codec_item_t;

  typedef struct {
    logic [ByteBits-1:0]  out_byte;
    logic                 run_last;
    logic [ValueBits-1:0] decoded_value;
    logic [CountBits-1:0] byte_count;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst;

  vb128_item_if   item_ch ();
  vb128_result_if result_ch ();
  vb128_cfg_if    cfg_ch ();

  varint_base128_codec_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus waiting for the driver, and coded bytes / values still owed by the codec.
  codec_item_t   items_pending[$];
  codec_result_t results_due[$];

  // Bench copy of the codec state: direction register and partial decode run.
  logic                 cur_dir;
  logic [ValueBits-1:0] partial_value;
  logic [CountBits-1:0] groups_taken;

  int mismatches = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stretch_left  = 0;
  int stall_mode    = 0;
  int idle_cycles   = 0;

  // Encode: little-endian 7-bit groups, continuation flag on all but the last;
  // after eight groups any leftover top bits go out as a raw ninth byte.
  task automatic split_into_groups(input logic [ValueBits-1:0] v);
    logic [ValueBits-1:0] rest;
    logic [ByteBits-1:0]  groups [9];
    logic [ByteBits-1:0]  g;
    codec_result_t        r;
    int                   n;
    int                   i;
    rest = v;
    n = 0;
    do begin
      g = rest[ByteBits-1:0] & GroupMask;
      rest = rest >> GroupBits;
      if (rest != '0) g = g | ContFlag;
      groups[n] = g;
      n++;
    end while (rest != '0 && n < MaxGroups);
    if (n == MaxGroups && rest != '0) begin
      groups[n] = rest[ByteBits-1:0];
      n++;
    end
    for (i = 0; i < n; i++) begin
      r.out_byte      = groups[i];
      r.run_last      = (i == n - 1);
      r.decoded_value = '0;
      r.byte_count    = (i == n - 1) ? CountBits'(n) : '0;
      results_due.push_back(r);
    end
  endtask

  // Decode: merge one coded byte; the ninth byte counts as a full 8-bit group
  // and always closes the run.
  task automatic merge_group(input logic [ByteBits-1:0] cb);
    logic          done;
    codec_result_t r;
    if (groups_taken >= LastGroup) begin
      partial_value = partial_value + (ValueBits'(cb) << (GroupBits * MaxGroups));
      groups_taken  = CountBits'(MaxGroups + 1);
      done = 1'b1;
    end else begin
      partial_value = partial_value +
                      (ValueBits'(cb & GroupMask) << (GroupBits * int'(groups_taken)));
      groups_taken  = groups_taken + 4'd1;
      done = ((cb & ContFlag) == '0);
    end
    if (done) begin
      r.out_byte      = '0;
      r.run_last      = 1'b1;
      r.decoded_value = partial_value;
      r.byte_count    = groups_taken;
      results_due.push_back(r);
      partial_value = '0;
      groups_taken  = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [ValueBits-1:0] want,
                             input logic [ValueBits-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Encode-mode item; the coded byte rides along as noise.
  task automatic queue_value(input logic [ValueBits-1:0] v);
    codec_item_t it;
    it.plain_value = v;
    it.coded_byte  = ByteBits'($urandom);
    items_pending.push_back(it);
  endtask

  // Decode-mode item; the plain value rides along as noise.
  task automatic queue_byte(input logic [ByteBits-1:0] b);
    codec_item_t it;
    it.plain_value = {$urandom, $urandom};
    it.coded_byte  = b;
    items_pending.push_back(it);
  endtask

  // Direction write; the codec must be idle. Returns on a falling edge.
  task automatic set_direction(input logic d);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.direction <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    // any write also drops a partial decode run
    cur_dir       = d;
    partial_value = '0;
    groups_taken  = '0;
    @(negedge clk);
  endtask

  // Wait for all queued items to go in and all owed results to come out, then
  // give the codec time to finish work that produces no result.
  task automatic drain_and_settle();
    while (items_pending.size() != 0 || item_ch.valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Driver: bursts of random length separated by random gaps. The item is
  // handed to the bench copy of the codec at the edge where it is accepted.
  always @(posedge clk) begin : drive_items
    codec_item_t nxt;
    logic        took;
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      took = item_ch.valid && item_ch.ready;
      if (took) begin
        if (cur_dir == DirEncode) split_into_groups(item_ch.plain_value);
        else merge_group(item_ch.coded_byte);
      end
      if (took || !item_ch.valid) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (items_pending.size() > 0) begin
          nxt = items_pending.pop_front();
          item_ch.plain_value <= nxt.plain_value;
          item_ch.coded_byte  <= nxt.coded_byte;
          item_ch.valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip or sparse ready, plus a long
  // hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(10, 60);
          stall_mode   = $urandom_range(0, 2);
        end
        stretch_left--;
        case (stall_mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: every result transaction against the oldest owed result.
  always @(posedge clk) begin : check_results
    codec_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h/%b/%h/%h", $time,
                 result_ch.out_byte, result_ch.run_last, result_ch.decoded_value,
                 result_ch.byte_count);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("out_byte", ValueBits'(want.out_byte), ValueBits'(result_ch.out_byte));
        check_field("run_last", ValueBits'(want.run_last), ValueBits'(result_ch.run_last));
        check_field("decoded_value", want.decoded_value, result_ch.decoded_value);
        check_field("byte_count", ValueBits'(want.byte_count),
                    ValueBits'(result_ch.byte_count));
      end
    end
  end

  // Watchdog: too long without any transaction on any channel.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: no transaction for %0d cycles, %0d results still owed", $time,
                 idle_cycles, results_due.size());
        $display("** varint_base128_codec_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [ValueBits-1:0] v;
    int ph;
    int k;
    int j;
    int n_items;

    rst = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.plain_value = '0;
    item_ch.coded_byte  = '0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.direction    = DirEncode;
    cur_dir       = DirEncode;
    partial_value = '0;
    groups_taken  = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed encode: group-count boundaries, the raw ninth byte, extremes.
    set_direction(DirEncode);
    queue_value(64'd0);
    queue_value(64'd1);
    queue_value(64'd127);
    queue_value(64'd128);
    queue_value(64'd16384);
    queue_value(64'h00FF_FFFF_FFFF_FFFF);   // largest eight-group value
    queue_value(64'h0100_0000_0000_0000);   // smallest nine-byte value
    queue_value(64'hFFFF_FFFF_FFFF_FFFF);
    queue_value(64'h8000_0000_0000_0000);
    queue_value(64'hAAAA_AAAA_AAAA_AAAA);
    drain_and_settle();

    // Directed decode: one-byte runs, a two-byte run, a full nine-byte run.
    set_direction(DirDecode);
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'h80);
    queue_byte(8'h01);
    for (j = 0; j < 9; j++) queue_byte(8'hFF);
    // a run left open, then abandoned by rewriting the same direction
    queue_byte(8'h85);
    queue_byte(8'h90);
    drain_and_settle();
    set_direction(DirDecode);
    queue_byte(8'h05);
    drain_and_settle();

    // Random phases, alternating direction; two of them start with a long
    // receiver hold-off so the codec backs up and stalls its input.
    for (ph = 0; ph < 6; ph++) begin
      set_direction((ph % 2 == 0) ? DirEncode : DirDecode);
      if (ph == 0 || ph == 3) hold_requests++;
      if (ph % 2 == 0) begin
        for (j = 0; j < PhaseItems; j++) begin
          v = {$urandom, $urandom};
          k = $urandom_range(1, 9);
          if ($urandom_range(0, 4) != 0 && k < 9) begin
            // trim to k groups, usually with the top group non-zero
            v = v & ((64'd1 << (GroupBits * k)) - 64'd1);
            if ($urandom_range(0, 1) == 1) v = v | (64'd1 << (GroupBits * k - 1));
          end
          if ($urandom_range(0, 30) == 0) v = '0;
          queue_value(v);
        end
      end else begin
        n_items = 0;
        while (n_items < PhaseItems) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_byte(ByteBits'($urandom));   // noise byte, either flag value
            n_items++;
          end else begin
            k = $urandom_range(1, 9);
            for (j = 0; j < k - 1; j++) queue_byte({1'b1, 7'($urandom)});
            if (k == 9) queue_byte(ByteBits'($urandom));
            else queue_byte({1'b0, 7'($urandom)});
            n_items += k;
          end
        end
        // leave a run open for the next direction write to throw away
        k = $urandom_range(0, 3);
        for (j = 0; j < k; j++) queue_byte({1'b1, 7'($urandom)});
      end
      drain_and_settle();
    end

    if (results_due.size() != 0) begin
      $display("%0t ns: %0d results owed at end, expected 0, actual %0d", $time,
               results_due.size(), results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** varint_base128_codec_top: PASSED **");
    end else begin
      $display("** varint_base128_codec_top: FAILED **");
    end
    $finish;
  end

endmodule
